// File: design/suffix_range_min_dsu_macros.svh
// ----------------------------------------------------------------------------
// suffix_range_min_dsu_macros.svh
// assertion macros for the suffix range-minimum block, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef SUFFIX_RANGE_MIN_DSU_MACROS_SVH
`define SUFFIX_RANGE_MIN_DSU_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define SRMD_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// checked on every edge, reset included
`define SRMD_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) (prop)) else $error(msg);
`else
`define SRMD_ASSERT(lbl, ck, rn, prop, msg)
`define SRMD_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif
`endif

// File: design/srmd_pkg.sv
// ----------------------------------------------------------------------------
// srmd_pkg
// shared types, codes and constants of the suffix range-minimum block
// ----------------------------------------------------------------------------
package srmd_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int VALUE_BITS = 32;
  localparam int LEFT_BITS  = 10;

  // request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // per-row shift operations of the cell chain
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;  // take the entry of the previous cell
  localparam logic [1:0] OP_POP  = 2'd2;  // take the entry of the next cell

  typedef struct packed {
    logic                          req_type;
    logic signed [VALUE_BITS-1:0]  value;
    logic        [LEFT_BITS-1:0]   left_index;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  min_value;
    logic        [1:0]             status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] main_op;
    logic [1:0] aside_op;
  } chain_ctl_t;

endpackage

// File: design/srmd_cell.sv
// ----------------------------------------------------------------------------
// srmd_cell
// one cell of the stack chain: a main entry and an aside entry, each shifting
// toward either neighbor
// ----------------------------------------------------------------------------
module srmd_cell import srmd_pkg::*; #(
  parameter int EW = 1 + $clog2(DEPTH_DEF) + VALUE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chain_ctl_t    ctl,
  input  logic [EW-1:0] main_prev,
  input  logic [EW-1:0] main_next,
  input  logic [EW-1:0] aside_prev,
  input  logic [EW-1:0] aside_next,
  output logic [EW-1:0] main_q,
  output logic [EW-1:0] aside_q
);

  logic          main_vld_r;
  logic [EW-2:0] main_dat_r;
  logic          aside_vld_r;
  logic [EW-2:0] aside_dat_r;
  logic [EW-1:0] main_nxt;
  logic [EW-1:0] aside_nxt;

  assign main_q  = {main_vld_r, main_dat_r};
  assign aside_q = {aside_vld_r, aside_dat_r};

  always_comb begin
    unique case (ctl.main_op)
      OP_HOLD: main_nxt = main_q;
      OP_PUSH: main_nxt = main_prev;
      OP_POP:  main_nxt = main_next;
      default: main_nxt = main_q;
    endcase
  end

  always_comb begin
    unique case (ctl.aside_op)
      OP_HOLD: aside_nxt = aside_q;
      OP_PUSH: aside_nxt = aside_prev;
      OP_POP:  aside_nxt = aside_next;
      default: aside_nxt = aside_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r  <= 1'b0;
      aside_vld_r <= 1'b0;
    end else begin
      main_vld_r  <= main_nxt[EW-1];
      aside_vld_r <= aside_nxt[EW-1];
    end
  end

  always_ff @(posedge clk) begin
    main_dat_r  <= main_nxt[EW-2:0];
    aside_dat_r <= aside_nxt[EW-2:0];
  end

endmodule

// File: design/suffix_range_min_dsu.sv
// ----------------------------------------------------------------------------
// suffix_range_min_dsu
// suffix range-minimum over an append-only array, kept as a monotonic stack
// in a chain of shifting cells
// ----------------------------------------------------------------------------
// Each transfer on the input channel gives exactly one result transfer. An
// append stores value as the next element (status ok, min_value 0), or is
// dropped with status store-full once DEPTH elements are held. A query
// returns the minimum from left_index through the newest element, or status
// bad-index with min_value 0 when left_index is not below the element count.
// Only the monotonic stack is stored: cell 0 holds the newest stack entry,
// deeper cells hold older positions with values that never increase. The
// chain moves one cell per cycle, and that shift sets the timing. An append
// pops each stack entry larger than its value, one by one, and then pushes
// the new entry; a query shifts aside the stack entries newer than the entry
// that answers it and then shifts them back; a full store or a bad index goes
// straight to the result. One item is worked on at a time; the next input
// transfer can be taken once the result is in the output register, even
// while that result still waits to be taken. A result that waits in the
// output register holds the finished item in its last step. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
`include "suffix_range_min_dsu_macros.svh"

module suffix_range_min_dsu import srmd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = 1 + POS_W + VALUE_BITS;
  // compare width for positions, counts and left index
  localparam int CMP_W0 = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int CMP_W  = (CMP_W0 > LEFT_BITS) ? CMP_W0 : LEFT_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APOP  = 3'd1;  // pop larger entries, then push
  localparam logic [2:0] S_QWALK = 3'd2;  // shift newer entries aside
  localparam logic [2:0] S_QREST = 3'd3;  // shift them back
  localparam logic [2:0] S_DONE  = 3'd4;  // hand result to output register

  logic [2:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [VALUE_BITS-1:0] val_r;
  logic [LEFT_BITS-1:0]         left_r;
  logic signed [VALUE_BITS-1:0] res_val_r, res_val_nxt;
  logic [1:0]                   res_st_r, res_st_nxt;
  logic                         out_valid_r;
  out_item_t                    out_data_r;
  logic                         load_out;

  chain_ctl_t                   ctl;
  logic [EW-1:0]                main_head;
  logic [EW-1:0]                new_entry;
  logic [EW-1:0]                main_q  [DEPTH];
  logic [EW-1:0]                aside_q [DEPTH];

  // the two newest stack entries and the newest aside entry
  logic                         m0_vld, m1_vld, a0_vld;
  logic signed [VALUE_BITS-1:0] m0_val, m1_val;
  logic [POS_W-1:0]             m0_pos, m1_pos;
  logic [CMP_W-1:0]             m1_pos_ext, m0_pos_ext;
  logic [CMP_W-1:0]             left_ext, left_in_ext, cnt_ext;
  logic                         full;

  assign m0_vld = main_q[0][EW-1];
  assign m1_vld = main_q[1][EW-1];
  assign a0_vld = aside_q[0][EW-1];
  assign m0_val = $signed(main_q[0][VALUE_BITS-1:0]);
  assign m1_val = $signed(main_q[1][VALUE_BITS-1:0]);
  assign m0_pos = main_q[0][VALUE_BITS +: POS_W];
  assign m1_pos = main_q[1][VALUE_BITS +: POS_W];

  assign m0_pos_ext  = CMP_W'(m0_pos);
  assign m1_pos_ext  = CMP_W'(m1_pos);
  assign left_ext    = CMP_W'(left_r);
  assign left_in_ext = CMP_W'(in_data.left_index);
  assign cnt_ext     = CMP_W'(cnt_r);
  assign full        = (cnt_r == CNT_W'(DEPTH));

  // a new element always lands at position element_count
  assign new_entry = {1'b1, cnt_r[POS_W-1:0], val_r};
  // cell 0 takes the new element on append, the aside entry on restore
  assign main_head = (state_r == S_APOP) ? new_entry : aside_q[0];

  // ---------------------------------------------------------------- chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] mp, mn, ap, an;
    if (i == 0) begin : g_head
      assign mp = main_head;
      assign ap = main_q[0];        // entry moving aside comes from main top
    end else begin : g_body
      assign mp = main_q[i-1];
      assign ap = aside_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign mn = '0;               // an empty entry enters at the tail
      assign an = '0;
    end else begin : g_mid
      assign mn = main_q[i+1];
      assign an = aside_q[i+1];
    end

    srmd_cell #(
      .EW (EW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .main_prev  (mp),
      .main_next  (mn),
      .aside_prev (ap),
      .aside_next (an),
      .main_q     (main_q[i]),
      .aside_q    (aside_q[i])
    );
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    res_val_nxt  = res_val_r;
    res_st_nxt   = res_st_r;
    load_out     = 1'b0;
    ctl.main_op  = OP_HOLD;
    ctl.aside_op = OP_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_val_nxt = '0;
          res_st_nxt  = ST_OK;
          if (in_data.req_type == REQ_APPEND) begin
            if (full) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_APOP;
            end
          end else begin
            if (left_in_ext >= cnt_ext) begin
              res_st_nxt = ST_BAD_INDEX;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_QWALK;
            end
          end
        end
      end
      S_APOP: begin
        // strictly greater entries leave; equal ones stay
        if (m0_vld && (m0_val > val_r)) begin
          ctl.main_op = OP_POP;
        end else begin
          ctl.main_op = OP_PUSH;
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = S_DONE;
        end
      end
      S_QWALK: begin
        // answer is the oldest stack entry at or after left
        if (m1_vld && (m1_pos_ext >= left_ext)) begin
          ctl.main_op  = OP_POP;
          ctl.aside_op = OP_PUSH;
        end else begin
          res_val_nxt = m0_val;
          state_nxt   = S_QREST;
        end
      end
      S_QREST: begin
        if (a0_vld) begin
          ctl.main_op  = OP_PUSH;
          ctl.aside_op = OP_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      val_r  <= in_data.value;
      left_r <= in_data.left_index;
    end
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    if (load_out) begin
      out_data_r.min_value <= res_val_r;
      out_data_r.status    <= res_st_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ----------------------------------------------------------- assertions
  `SRMD_ASSERT(a_walk_top_valid, clk, rst_n,
    (state_r == S_QWALK) |-> (m0_vld && (m0_pos_ext >= left_ext)),
    "query walk lost the newest entry")
  `SRMD_ASSERT(a_idle_aside_empty, clk, rst_n,
    (state_r == S_IDLE) |-> !a0_vld,
    "aside row not restored")
  `SRMD_ASSERT(a_stack_monotone, clk, rst_n,
    (state_r == S_IDLE && m0_vld && m1_vld) |-> (m1_val <= m0_val && m1_pos < m0_pos),
    "stack order broken")
  `SRMD_ASSERT(a_stack_vs_count, clk, rst_n,
    (state_r == S_IDLE) |-> (m0_vld == (cnt_r != '0)),
    "stack and element count disagree")
  `SRMD_ASSERT_ALWAYS(a_reset_out, clk,
    !rst_n |=> !out_valid_r,
    "result valid after reset")

endmodule
